[hdl/flow_table_new_flow_detect_top_defines.svh]
// Assertion macros shared by the flow table design.
`ifndef FLOW_TABLE_NEW_FLOW_DETECT_TOP_DEFINES_SVH
`define FLOW_TABLE_NEW_FLOW_DETECT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk and disabled while aresetn is low.
`define FTD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and disabled while aresetn is low.
`define FTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ftd_pkg.sv]
// Types, constants and helpers shared by the flow table modules.
`timescale 1ns / 1ps
package ftd_pkg;

    localparam int SLOT_W = 8;
    localparam int CNT_W = 9;
    localparam logic [7:0] TCP_PROTO = 8'd6;
    localparam logic [CNT_W-1:0] COUNT_MAX = 9'd511;

    typedef struct packed {
        logic [7:0]  proto_num;
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
    } key_t;

    typedef struct packed {
        logic              valid;
        logic              found;
        logic              is_new;
        logic [SLOT_W-1:0] slot;
        key_t              key;
    } cell_bus_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

[hdl/flow_table_new_flow_detect_top.sv]
// Top level of the five-tuple flow table with new-flow detection.
// Usage:
// The slave channel takes one packet five-tuple per transaction on s_tdata.
// The master channel returns one result per input transaction, in order:
// the new-flow and table-full flags on m_tuser and the slot and flow counts
// on m_tdata. The table is a row of FLOW_ENTRIES cells; each transaction
// walks one cell per cycle while the output is not stalled, is compared
// with the stored key there and claims the first empty cell if no earlier
// cell matched. A result passes through the cell registers in order and
// then the output register. Up to FLOW_ENTRIES + 1 transactions are in
// flight, one per cell plus the output register, so one transaction is
// accepted every cycle while the output is not stalled.
// Reset clears all valid bits, the three counters and the pipeline.
// When the receiver holds m_tready low with a result waiting, the whole
// chain and s_tready stall until that result is taken.
`timescale 1ns / 1ps
`include "flow_table_new_flow_detect_top_defines.svh"
module flow_table_new_flow_detect_top
    import ftd_pkg::*;
#(
    parameter int FLOW_ENTRIES = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata: src_addr[31:0], dst_addr[63:32], src_port[79:64],
    // dst_port[95:80], proto_num[103:96]
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: flow_slot[7:0], flows_total[16:8], flows_tcp[25:17],
    // flows_other[34:26], zero[39:35]
    output logic [39:0]  m_tdata,
    // m_tuser: is_new_flow[0], table_full[1]
    output logic [1:0]   m_tuser
);

    cell_bus_t chain [FLOW_ENTRIES+1];
    cell_bus_t head;
    cell_bus_t last;
    logic      advance;
    logic      out_load;
    logic      last_tcp;

    logic              m_tvalid_reg, m_tvalid_next;
    logic              is_new_reg, is_new_next;
    logic              full_reg, full_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  count_total_reg, count_total_next;
    logic [CNT_W-1:0]  count_tcp_reg, count_tcp_next;
    logic [CNT_W-1:0]  count_other_reg, count_other_next;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance && aresetn;

    always_comb begin
        head               = '0;
        head.valid         = s_tvalid;
        head.key.src_addr  = s_tdata[31:0];
        head.key.dst_addr  = s_tdata[63:32];
        head.key.src_port  = s_tdata[79:64];
        head.key.dst_port  = s_tdata[95:80];
        head.key.proto_num = s_tdata[103:96];
    end

    assign chain[0] = head;

    for (genvar i = 0; i < FLOW_ENTRIES; i++) begin : g_cell
        ftd_cell #(
            .INDEX (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .in_bus  (chain[i]),
            .out_bus (chain[i+1])
        );
    end

    assign last     = chain[FLOW_ENTRIES];
    assign out_load = advance && last.valid;
    assign last_tcp = (last.key.proto_num == TCP_PROTO);

    always_comb begin
        m_tvalid_next    = m_tvalid_reg;
        is_new_next      = is_new_reg;
        full_next        = full_reg;
        slot_next        = slot_reg;
        count_total_next = count_total_reg;
        count_tcp_next   = count_tcp_reg;
        count_other_next = count_other_reg;
        if (advance) begin
            m_tvalid_next = last.valid;
        end
        if (out_load) begin
            is_new_next = last.is_new;
            full_next   = !last.found;
            slot_next   = last.slot;
            if (last.is_new) begin
                count_total_next = sat_inc(count_total_reg);
                if (last_tcp) begin
                    count_tcp_next = sat_inc(count_tcp_reg);
                end else begin
                    count_other_next = sat_inc(count_other_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg    <= 1'b0;
            count_total_reg <= '0;
            count_tcp_reg   <= '0;
            count_other_reg <= '0;
        end else begin
            m_tvalid_reg    <= m_tvalid_next;
            count_total_reg <= count_total_next;
            count_tcp_reg   <= count_tcp_next;
            count_other_reg <= count_other_next;
        end
    end

    always_ff @(posedge aclk) begin
        is_new_reg <= is_new_next;
        full_reg   <= full_next;
        slot_reg   <= slot_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = {full_reg, is_new_reg};
    assign m_tdata  = {5'b0, count_other_reg, count_tcp_reg, count_total_reg, slot_reg};

    `FTD_ASSERT_NOW(a_new_not_full, m_tvalid_reg, !(is_new_reg && full_reg), "new flow reported as table full")
    `FTD_ASSERT_NOW(a_full_slot_zero, m_tvalid_reg && full_reg, slot_reg == '0, "table full result with nonzero slot")
    `FTD_ASSERT_NEXT(a_count_hold, !out_load, $stable(count_total_reg) && $stable(count_tcp_reg) && $stable(count_other_reg), "flow counts changed without a result")
    `FTD_ASSERT_NEXT(a_stall_hold, m_tvalid_reg && !m_tready, $stable(last) && $stable(count_total_reg), "chain moved while output stalled")

endmodule

[hdl/ftd_cell.sv]
// One table slot: stores a flow key, matches or claims it for the passing transaction.
`timescale 1ns / 1ps
module ftd_cell
    import ftd_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  cell_bus_t in_bus,
    output cell_bus_t out_bus
);

    localparam logic [SLOT_W-1:0] CELL_SLOT = SLOT_W'(INDEX);

    logic      entry_valid_reg;
    logic      entry_valid_next;
    key_t      entry_key_reg;
    cell_bus_t out_reg;
    cell_bus_t out_next;
    logic      hit;
    logic      claim;

    always_comb begin
        hit   = in_bus.valid && !in_bus.found && entry_valid_reg &&
                (entry_key_reg == in_bus.key);
        claim = in_bus.valid && !in_bus.found && !entry_valid_reg;
        out_next = in_bus;
        if (hit || claim) begin
            out_next.found = 1'b1;
            out_next.slot  = CELL_SLOT;
        end
        if (claim) begin
            out_next.is_new = 1'b1;
        end
        entry_valid_next = entry_valid_reg || (advance && claim);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= 1'b0;
            out_reg         <= '0;
        end else begin
            entry_valid_reg <= entry_valid_next;
            if (advance) begin
                out_reg <= out_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && claim) begin
            entry_key_reg <= in_bus.key;
        end
    end

    assign out_bus = out_reg;

endmodule
